@@ design/scd_pkg.sv @@
// Shared constants, register indexes and controller/datapath interface types.
`default_nettype none

package scd_pkg;

    localparam int VOLT_W      = 32;
    localparam int TIME_W      = 48;
    localparam int INDEX_W     = 24;
    localparam int COUNT_W     = 17;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 48;

    // Low half of the time difference feeds the first partial product.
    localparam int DELTA_LO_W = 24;
    localparam int DELTA_HI_W = TIME_W - DELTA_LO_W;
    localparam int PROD_W     = VOLT_W + TIME_W;

    // One quotient bit per divider step.
    localparam int DIV_STEPS = TIME_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CFG_INDEX_W-1:0] CFG_TIME_BEFORE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIME_NOW    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_BASE  = 2'd2;

    typedef struct packed {
        logic accept;
        logic mul_lo;
        logic mul_hi;
        logic div_step;
        logic load_out;
    } scd_cmd_t;

    typedef struct packed {
        logic in_spike;
        logic in_last;
    } scd_status_t;

endpackage

`default_nettype wire

@@ design/scd_datapath.sv @@
// Datapath: configuration, step counters, multiplier, restoring divider, result register.
`default_nettype none

module scd_datapath
    import scd_pkg::*;
#(
    parameter int MAX_NEURONS_PER_STEP = 65536
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]     cfg_data,
    input  wire logic signed [VOLT_W-1:0]  voltage_now,
    input  wire logic signed [VOLT_W-1:0]  voltage_before,
    input  wire logic                      end_of_step,
    input  wire scd_cmd_t                  cmd,
    output scd_status_t                    status,
    output logic                           is_spike,
    output logic [INDEX_W-1:0]             neuron_index,
    output logic [TIME_W-1:0]              spike_time,
    output logic [COUNT_W-1:0]             spike_count,
    output logic                           step_done
);

    localparam int POS_W   = (MAX_NEURONS_PER_STEP > 1) ? $clog2(MAX_NEURONS_PER_STEP) : 1;
    localparam int CAP_INT = (MAX_NEURONS_PER_STEP < 131071) ? MAX_NEURONS_PER_STEP : 131071;
    localparam logic [POS_W-1:0]   POS_MAX   = POS_W'(MAX_NEURONS_PER_STEP - 1);
    localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(CAP_INT);

    // Configuration registers.
    logic [TIME_W-1:0]  time_before_reg, time_before_next;
    logic [TIME_W-1:0]  time_now_reg, time_now_next;
    logic [INDEX_W-1:0] index_base_reg, index_base_next;

    // Step counters.
    logic [POS_W-1:0]   position_reg, position_next;
    logic [COUNT_W-1:0] spikes_reg, spikes_next;

    // Per-request operands and result fields.
    logic [VOLT_W-1:0]  w_reg, w_next;
    logic [VOLT_W-1:0]  d_reg, d_next;
    logic [TIME_W-1:0]  delta_reg, delta_next;
    logic [TIME_W-1:0]  tlo_reg, tlo_next;
    logic               res_spike_reg, res_spike_next;
    logic               res_last_reg, res_last_next;
    logic [INDEX_W-1:0] res_index_reg, res_index_next;
    logic [COUNT_W-1:0] res_count_reg, res_count_next;

    // Product, then partial remainder (high part) and dividend/quotient shifter (low part).
    logic [VOLT_W-1:0]  rem_reg, rem_next;
    logic [TIME_W-1:0]  quo_reg, quo_next;

    // Output register.
    logic               out_spike_reg, out_spike_next;
    logic [INDEX_W-1:0] out_index_reg, out_index_next;
    logic [TIME_W-1:0]  out_time_reg, out_time_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic               out_done_reg, out_done_next;

    logic                      in_spike;
    logic                      time_rising;
    logic [VOLT_W-1:0]         mag_now;
    logic [VOLT_W-1:0]         mag_before;
    logic [INDEX_W:0]          index_sum;
    logic [COUNT_W-1:0]        count_inc;
    logic [DELTA_LO_W-1:0]     mul_operand;
    logic [VOLT_W+DELTA_LO_W-1:0] partial;
    logic [PROD_W-1:0]         prod_sum;
    logic [VOLT_W:0]           shifted;
    logic [VOLT_W+1:0]         trial;
    logic                      trial_fits;

    assign in_spike    = voltage_before[VOLT_W-1] & ~voltage_now[VOLT_W-1];
    assign status      = '{in_spike: in_spike, in_last: end_of_step};
    assign time_rising = (time_now_reg >= time_before_reg);
    assign mag_now     = voltage_now;
    assign mag_before  = ~voltage_before + VOLT_W'(1);
    assign index_sum   = {1'b0, index_base_reg} + (INDEX_W+1)'(position_reg);
    assign count_inc   = spikes_reg
                         + COUNT_W'(in_spike && (spikes_reg < COUNT_CAP));

    // One shared 32x24 multiplier; the high half is added in on the mul_hi step, after the mul_lo step.
    assign mul_operand = cmd.mul_hi ? delta_reg[TIME_W-1:DELTA_LO_W]
                                    : delta_reg[DELTA_LO_W-1:0];
    assign partial     = w_reg * mul_operand;
    assign prod_sum    = {rem_reg, quo_reg} + {partial, {DELTA_LO_W{1'b0}}};

    // Restoring division step.
    assign shifted    = {rem_reg, quo_reg[TIME_W-1]};
    assign trial      = {1'b0, shifted} - {2'b00, d_reg};
    assign trial_fits = ~trial[VOLT_W+1];

    always_comb
    begin
        time_before_next = time_before_reg;
        time_now_next    = time_now_reg;
        index_base_next  = index_base_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TIME_BEFORE: time_before_next = cfg_data[TIME_W-1:0];
                CFG_TIME_NOW:    time_now_next    = cfg_data[TIME_W-1:0];
                CFG_INDEX_BASE:  index_base_next  = cfg_data[INDEX_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        position_next  = position_reg;
        spikes_next    = spikes_reg;
        w_next         = w_reg;
        d_next         = d_reg;
        delta_next     = delta_reg;
        tlo_next       = tlo_reg;
        res_spike_next = res_spike_reg;
        res_last_next  = res_last_reg;
        res_index_next = res_index_reg;
        res_count_next = res_count_reg;
        if (cmd.accept)
        begin
            res_spike_next = in_spike;
            res_last_next  = end_of_step;
            res_count_next = count_inc;
            if (!in_spike)
                res_index_next = '0;
            else if (index_sum[INDEX_W])
                res_index_next = '1;
            else
                res_index_next = index_sum[INDEX_W-1:0];
            d_next = mag_now + mag_before;
            if (time_rising)
            begin
                w_next     = mag_before;
                delta_next = time_now_reg - time_before_reg;
                tlo_next   = time_before_reg;
            end
            else
            begin
                w_next     = mag_now;
                delta_next = time_before_reg - time_now_reg;
                tlo_next   = time_now_reg;
            end
            if (end_of_step)
            begin
                position_next = '0;
                spikes_next   = '0;
            end
            else
            begin
                spikes_next = count_inc;
                if (position_reg < POS_MAX)
                    position_next = position_reg + POS_W'(1);
            end
        end
    end

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (cmd.mul_lo)
            {rem_next, quo_next} = PROD_W'(partial);
        else if (cmd.mul_hi)
            {rem_next, quo_next} = prod_sum;
        else if (cmd.div_step)
        begin
            rem_next = trial_fits ? trial[VOLT_W-1:0] : shifted[VOLT_W-1:0];
            quo_next = {quo_reg[TIME_W-2:0], trial_fits};
        end
    end

    always_comb
    begin
        out_spike_next = out_spike_reg;
        out_index_next = out_index_reg;
        out_time_next  = out_time_reg;
        out_count_next = out_count_reg;
        out_done_next  = out_done_reg;
        if (cmd.load_out)
        begin
            out_spike_next = res_spike_reg;
            out_index_next = res_index_reg;
            out_time_next  = res_spike_reg ? (tlo_reg + quo_reg) : '0;
            out_count_next = res_count_reg;
            out_done_next  = res_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_before_reg <= '0;
            time_now_reg    <= '0;
            index_base_reg  <= '0;
            position_reg    <= '0;
            spikes_reg      <= '0;
        end
        else
        begin
            time_before_reg <= time_before_next;
            time_now_reg    <= time_now_next;
            index_base_reg  <= index_base_next;
            position_reg    <= position_next;
            spikes_reg      <= spikes_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg         <= w_next;
        d_reg         <= d_next;
        delta_reg     <= delta_next;
        tlo_reg       <= tlo_next;
        res_spike_reg <= res_spike_next;
        res_last_reg  <= res_last_next;
        res_index_reg <= res_index_next;
        res_count_reg <= res_count_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        out_spike_reg <= out_spike_next;
        out_index_reg <= out_index_next;
        out_time_reg  <= out_time_next;
        out_count_reg <= out_count_next;
        out_done_reg  <= out_done_next;
    end

    assign is_spike     = out_spike_reg;
    assign neuron_index = out_index_reg;
    assign spike_time   = out_time_reg;
    assign spike_count  = out_count_reg;
    assign step_done    = out_done_reg;

endmodule

`default_nettype wire

@@ design/scd_ctrl.sv @@
// Controller: request sequencing, divider step count and output valid flag.
`default_nettype none

module scd_ctrl
    import scd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire scd_status_t status,
    output scd_cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL_LO = 3'd1;
    localparam logic [2:0] ST_MUL_HI = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    logic [2:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 accept;
    logic                 slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        cmd.accept   = accept;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (status.in_spike)
                        state_next = ST_MUL_LO;
                    else if (status.in_last)
                        state_next = ST_FINISH;
                end
            end
            ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                cmd.mul_hi   = 1'b1;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_LAST)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A result is never written over one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while still held");

    // A spiking request always starts the multiplier.
    a_spike_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status.in_spike) |=> (state_reg == ST_MUL_LO))
        else $error("spike request did not start the multiplier");

    // The divider always starts from step zero.
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL_HI) |=> (state_reg == ST_DIV && div_cnt_reg == '0))
        else $error("divider started with a stale step count");

    // Work on a request blocks new input until its result is loaded; checked here in ST_DIV.
    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> !in_ready)
        else $error("input taken while the divider is busy");

endmodule

`default_nettype wire

@@ design/spike_crossing_detector.sv @@
// Top level of the spike crossing detector: controller and datapath.
//
// Usage: requests on the input channel carry one neuron's voltage now and at
// the previous step, in neuron order, with end_of_step set on the last neuron.
// A request is taken when in_valid and in_ready are both high. A neuron whose
// voltage crosses zero upward produces one result with its global index,
// the linearly interpolated crossing time and the running spike count; the
// last neuron of a step always produces a result with step_done set and the
// step total, after which the counters clear.
// Sequencing: a request with neither a spike nor end_of_step leaves the
// controller idle and ready for input; an end of step without a spike goes to
// ST_FINISH. A spike is taken in ST_IDLE, then passes through ST_MUL_LO and
// ST_MUL_HI (low and high halves of the 32x24 multiplier), ST_DIV (the
// one-bit-per-cycle restoring divider) and ST_FINISH, which loads the result
// register once it is free. This register sits between the two sides, so a new
// request is taken while a finished result waits for out_ready; a stalled
// receiver blocks input only once a second result is ready to be loaded.
// Reset clears the configuration registers, the step counters and the
// output valid flag. Configuration writes are registered; the user must make
// them only while the block is idle, which the block itself does not enforce.
`default_nettype none

module spike_crossing_detector
    import scd_pkg::*;
#(
    parameter int MAX_NEURONS_PER_STEP = 65536
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic signed [VOLT_W-1:0]  voltage_now,
    input  wire logic signed [VOLT_W-1:0]  voltage_before,
    input  wire logic                      end_of_step,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           is_spike,
    output logic [INDEX_W-1:0]             neuron_index,
    output logic [TIME_W-1:0]              spike_time,
    output logic [COUNT_W-1:0]             spike_count,
    output logic                           step_done
);

    scd_cmd_t    cmd;
    scd_status_t status;

    // Sequencing of each request through multiply, divide and output load.
    scd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Crossing detection, counters and the interpolation arithmetic.
    scd_datapath #(
        .MAX_NEURONS_PER_STEP (MAX_NEURONS_PER_STEP)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .voltage_now    (voltage_now),
        .voltage_before (voltage_before),
        .end_of_step    (end_of_step),
        .cmd            (cmd),
        .status         (status),
        .is_spike       (is_spike),
        .neuron_index   (neuron_index),
        .spike_time     (spike_time),
        .spike_count    (spike_count),
        .step_done      (step_done)
    );

endmodule

`default_nettype wire
